FILE: sv/icfr_pkg.sv
// Shared types, codes and constants of the image chunk frame receiver.
// No dependencies; every other file but icfr_if refers to this package by scoped names.
`default_nettype none

package icfr_pkg;

    // Packet type codes, taken from the first byte of a packet
    localparam logic [7:0] KIND_HEADER = 8'hA1;
    localparam logic [7:0] KIND_DATA   = 8'hA2;
    localparam logic [7:0] KIND_TAIL   = 8'hA3;

    // Line end characters
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // Byte position within a packet, saturating
    localparam int unsigned POS_W = 3;
    localparam logic [POS_W-1:0] POS_TYPE    = 3'd0;
    localparam logic [POS_W-1:0] POS_IDX_HI  = 3'd1;
    localparam logic [POS_W-1:0] POS_IDX_LO  = 3'd2;
    localparam logic [POS_W-1:0] POS_PAYLOAD = 3'd3;
    localparam logic [POS_W-1:0] POS_LEN_LO  = 3'd4;
    localparam logic [POS_W-1:0] POS_CHK_HI  = 3'd5;
    localparam logic [POS_W-1:0] POS_CHK_LO  = 3'd6;
    localparam logic [POS_W-1:0] POS_MAX     = 3'd7;

    // Result kinds
    typedef enum logic [1:0] {
        EV_TEXT  = 2'd0,
        EV_BEGIN = 2'd1,
        EV_END   = 2'd2
    } t_event;

    // Results caused by one byte: either one event or up to four characters
    typedef struct packed {
        t_event            evt;
        logic [2:0]        num;
        logic [31:0]       len;
        logic [15:0]       tot;
        logic [15:0]       rcv;
        logic [15:0]       gaps;
        logic [3:0][7:0]   chars;
    } t_bundle;

    // Lowercase hex digit for one nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'd0, nib};
        end else begin
            c = 8'h57 + {4'd0, nib};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: sv/icfr_if.sv
// Valid/ready channel interfaces of the image chunk frame receiver.
// Depends on nothing but the standard logic type.
`default_nettype none

interface icfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       packet_end;

    modport source (output valid, output rx_byte, output packet_end, input ready);
    modport sink   (input valid, input rx_byte, input packet_end, output ready);
endinterface

interface icfr_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_res;
    logic [7:0]  text_char;
    logic [31:0] image_length;
    logic [15:0] chunk_total;
    logic [15:0] chunks_received;
    logic [15:0] gap_count;
    logic        last;

    modport source (output valid, output event_res, output text_char, output image_length,
                    output chunk_total, output chunks_received, output gap_count,
                    output last, input ready);
    modport sink   (input valid, input event_res, input text_char, input image_length,
                    input chunk_total, input chunks_received, input gap_count,
                    input last, output ready);
endinterface

`default_nettype wire

FILE: sv/icfr_decode.sv
// Packet parser: per-image state and the result bundle for each byte.
// Depends on icfr_pkg.
`default_nettype none

module icfr_decode (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fire,
    input  wire logic [7:0]       i_byte,
    input  wire logic             i_end,
    output icfr_pkg::t_bundle     o_bundle
);

    logic [icfr_pkg::POS_W-1:0] r_pos,     n_pos;
    logic [7:0]                 r_kind,    n_kind;
    logic [31:0]                r_len_sh,  n_len_sh;
    logic [7:0]                 r_chk_sh,  n_chk_sh;
    logic [7:0]                 r_idx_hi,  n_idx_hi;
    logic [31:0]                r_cur_len, n_cur_len;
    logic [15:0]                r_cur_chk, n_cur_chk;
    logic [15:0]                r_acc,     n_acc;
    logic [15:0]                r_next,    n_next;
    logic [15:0]                r_gaps,    n_gaps;
    logic                       r_open,    n_open;
    logic                       r_dump,    n_dump;

    logic [15:0] new_chk;
    logic [15:0] idx;

    // Parse one byte: next state and the results it causes
    always_comb begin
        n_pos     = r_pos;
        n_kind    = r_kind;
        n_len_sh  = r_len_sh;
        n_chk_sh  = r_chk_sh;
        n_idx_hi  = r_idx_hi;
        n_cur_len = r_cur_len;
        n_cur_chk = r_cur_chk;
        n_acc     = r_acc;
        n_next    = r_next;
        n_gaps    = r_gaps;
        n_open    = r_open;
        n_dump    = r_dump;
        new_chk   = {r_chk_sh, i_byte};
        idx       = {r_idx_hi, i_byte};
        o_bundle  = '0;
        o_bundle.evt = icfr_pkg::EV_TEXT;

        if (r_pos == icfr_pkg::POS_TYPE) begin
            n_kind = i_byte;
            n_dump = 1'b0;
            // Close the open image on a tail
            if (i_byte == icfr_pkg::KIND_TAIL && r_open) begin
                o_bundle.evt  = icfr_pkg::EV_END;
                o_bundle.num  = 3'd1;
                o_bundle.len  = r_cur_len;
                o_bundle.tot  = r_cur_chk;
                o_bundle.rcv  = r_acc;
                o_bundle.gaps = r_gaps;
                n_open = 1'b0;
            end
        end else begin
            if (r_pos <= icfr_pkg::POS_LEN_LO) begin
                n_len_sh = {r_len_sh[23:0], i_byte};
            end
            if (r_pos == icfr_pkg::POS_IDX_HI) begin
                n_idx_hi = i_byte;
            end
            if (r_pos == icfr_pkg::POS_CHK_HI) begin
                n_chk_sh = i_byte;
            end

            // Header complete: open a new image unless it repeats the current one
            if (r_pos == icfr_pkg::POS_CHK_LO && r_kind == icfr_pkg::KIND_HEADER) begin
                if (!(r_open && r_len_sh == r_cur_len && new_chk == r_cur_chk)) begin
                    n_cur_len = r_len_sh;
                    n_cur_chk = new_chk;
                    n_acc     = '0;
                    n_next    = '0;
                    n_gaps    = '0;
                    n_open    = 1'b1;
                    o_bundle.evt = icfr_pkg::EV_BEGIN;
                    o_bundle.num = 3'd1;
                    o_bundle.len = r_len_sh;
                    o_bundle.tot = new_chk;
                end
            end

            // Data index complete: count the packet, check for a jump
            if (r_pos == icfr_pkg::POS_IDX_LO && r_kind == icfr_pkg::KIND_DATA && r_open) begin
                if (idx != r_next) begin
                    n_gaps = r_gaps + 16'd1;
                end
                n_next = idx + 16'd1;
                n_acc  = r_acc + 16'd1;
                n_dump = 1'b1;
            end else if (r_pos >= icfr_pkg::POS_PAYLOAD && r_dump) begin
                o_bundle.chars[0] = icfr_pkg::hex_char(i_byte[7:4]);
                o_bundle.chars[1] = icfr_pkg::hex_char(i_byte[3:0]);
                o_bundle.num      = 3'd2;
            end
        end

        // Packet end: finish the hex line and restart the position
        if (i_end) begin
            if (n_dump) begin
                if (o_bundle.num == 3'd0) begin
                    o_bundle.chars[0] = icfr_pkg::CHAR_CR;
                    o_bundle.chars[1] = icfr_pkg::CHAR_LF;
                end else begin
                    o_bundle.chars[2] = icfr_pkg::CHAR_CR;
                    o_bundle.chars[3] = icfr_pkg::CHAR_LF;
                end
                o_bundle.num = o_bundle.num + 3'd2;
            end
            n_dump = 1'b0;
            n_pos  = icfr_pkg::POS_TYPE;
        end else if (r_pos < icfr_pkg::POS_MAX) begin
            n_pos = r_pos + 3'd1;
        end
    end

    // Advance parser state on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= icfr_pkg::POS_TYPE;
            r_kind    <= '0;
            r_len_sh  <= '0;
            r_chk_sh  <= '0;
            r_idx_hi  <= '0;
            r_cur_len <= '0;
            r_cur_chk <= '0;
            r_acc     <= '0;
            r_next    <= '0;
            r_gaps    <= '0;
            r_open    <= 1'b0;
            r_dump    <= 1'b0;
        end else if (i_fire) begin
            r_pos     <= n_pos;
            r_kind    <= n_kind;
            r_len_sh  <= n_len_sh;
            r_chk_sh  <= n_chk_sh;
            r_idx_hi  <= n_idx_hi;
            r_cur_len <= n_cur_len;
            r_cur_chk <= n_cur_chk;
            r_acc     <= n_acc;
            r_next    <= n_next;
            r_gaps    <= n_gaps;
            r_open    <= n_open;
            r_dump    <= n_dump;
        end
    end

endmodule

`default_nettype wire

FILE: sv/icfr_emit.sv
// Result register: holds one byte's result bundle and hands it out one result a cycle while the sink is ready.
// Depends on icfr_pkg and icfr_out_if.
`default_nettype none

module icfr_emit (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire icfr_pkg::t_bundle i_bundle,
    output logic                  o_can_load,
    icfr_out_if.source            o_out
);

    icfr_pkg::t_bundle r_bundle;
    logic [2:0]        r_rem, n_rem;
    logic [1:0]        r_sel, n_sel;
    logic              out_fire;

    assign out_fire   = o_out.valid && o_out.ready;
    // Take a new bundle once the held one is gone or leaves this cycle
    assign o_can_load = (r_rem == 3'd0) || (r_rem == 3'd1 && o_out.ready);

    // Step through the held results
    always_comb begin
        n_rem = r_rem;
        n_sel = r_sel;
        if (i_load) begin
            n_rem = i_bundle.num;
            n_sel = 2'd0;
        end else if (out_fire) begin
            n_rem = r_rem - 3'd1;
            n_sel = r_sel + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
            r_sel <= '0;
        end else begin
            r_rem <= n_rem;
            r_sel <= n_sel;
        end
    end

    // Hold the payload of the current bundle
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bundle <= i_bundle;
        end
    end

    assign o_out.valid           = (r_rem != 3'd0);
    assign o_out.event_res       = r_bundle.evt;
    assign o_out.text_char       = r_bundle.chars[r_sel];
    assign o_out.image_length    = r_bundle.len;
    assign o_out.chunk_total     = r_bundle.tot;
    assign o_out.chunks_received = r_bundle.rcv;
    assign o_out.gap_count       = r_bundle.gaps;
    assign o_out.last            = (r_rem == 3'd1);

endmodule

`default_nettype wire

FILE: sv/image_chunk_frame_receiver.sv
// Image chunk frame receiver: top level joining the packet parser and the result register.
// Depends on icfr_pkg, icfr_if, icfr_decode and icfr_emit.
//
// Usage:
//   i_in carries received packet bytes with packet_end on the last byte of each packet.
//   o_out carries results: hex text characters (with CR/LF closing each data packet),
//   image-begin events from headers and image-end events from tails, with last set
//   on the final result caused by one byte.
//   Latency: results of a byte appear on o_out the cycle after the byte is accepted.
//   Throughput: a payload byte causes two results and the last payload byte of a packet
//   four; the result register hands out one result a cycle while the sink is ready,
//   and the parser takes the next byte in the cycle the last held result leaves.
//   Reset (i_rst_n low at a clock edge) closes any image, zeroes all counters and
//   drops held results.
//   When the sink stalls, the held result stays on o_out and i_in.ready stays low
//   for as long as any held result waits.
`default_nettype none

module image_chunk_frame_receiver (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    icfr_in_if.sink    i_in,
    icfr_out_if.source o_out
);

    icfr_pkg::t_bundle bundle;
    logic              can_load;
    logic              in_fire;

    assign i_in.ready = can_load;
    assign in_fire    = i_in.valid && can_load;

    icfr_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (in_fire),
        .i_byte   (i_in.rx_byte),
        .i_end    (i_in.packet_end),
        .o_bundle (bundle)
    );

    icfr_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (in_fire),
        .i_bundle   (bundle),
        .o_can_load (can_load),
        .o_out      (o_out)
    );

    // Events stand alone: each is the only result of its byte
    a_event_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.event_res != icfr_pkg::EV_TEXT |-> o_out.last)
        else $error("event result not marked last");

    // LF always closes the results of a byte
    a_lf_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.event_res == icfr_pkg::EV_TEXT
        && o_out.text_char == icfr_pkg::CHAR_LF |-> o_out.last)
        else $error("LF not marked last");

    // A new request only replaces the last held result as it leaves
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready && o_out.valid |-> o_out.ready && o_out.last)
        else $error("held result overwritten");

    // An accepted request with results shows valid output next cycle
    a_first_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && bundle.num != 3'd0 |=> o_out.valid)
        else $error("results of accepted request missing");

endmodule

`default_nettype wire

FILE: tb/icfr_frame_checker.sv
// Result checker of the image chunk frame receiver: watches both channels, predicts the
// results of every accepted byte and compares them in order. Depends on icfr_pkg, icfr_if.
module icfr_frame_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    icfr_in_if   i_in,
    icfr_out_if  i_out,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked,
    output int   o_begins,
    output int   o_ends
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        icfr_pkg::t_event evt;
        logic [7:0]       chr;
        logic [31:0]      len;
        logic [15:0]      tot;
        logic [15:0]      rcv;
        logic [15:0]      gaps;
        logic             last;
    } t_frame_result;

    localparam string HEX_SET = "0123456789abcdef";

    // Parser and image state of the predictor
    logic [2:0]  pkt_pos;
    logic [7:0]  pkt_type;
    logic [31:0] len_acc;
    logic [7:0]  chunks_hi;
    logic [7:0]  idx_hi;
    logic [31:0] img_len;
    logic [15:0] img_chunks;
    logic [15:0] data_count;
    logic [15:0] want_idx;
    logic [15:0] gap_total;
    logic        img_open;
    logic        hex_on;

    t_frame_result pending_results[$];
    t_frame_result head;

    function automatic t_frame_result text_res(input logic [7:0] c);
        t_frame_result r;
        r = '0;
        r.evt = icfr_pkg::EV_TEXT;
        r.chr = c;
        return r;
    endfunction

    function automatic t_frame_result status_res(input icfr_pkg::t_event e,
                                                 input logic [15:0] rcv,
                                                 input logic [15:0] gaps);
        t_frame_result r;
        r = '0;
        r.evt  = e;
        r.len  = img_len;
        r.tot  = img_chunks;
        r.rcv  = rcv;
        r.gaps = gaps;
        return r;
    endfunction

    // Advance the parser by one byte and queue the results it causes
    function automatic void predict_byte(input logic [7:0] b, input logic eop);
        t_frame_result batch [4];
        int            n;
        logic [2:0]    pos;
        logic [15:0]   idx;
        logic [15:0]   chunks_new;
        n   = 0;
        pos = pkt_pos;
        if (pos == icfr_pkg::POS_TYPE) begin
            pkt_type = b;
            hex_on   = 1'b0;
            if (b == icfr_pkg::KIND_TAIL && img_open) begin
                batch[n++] = status_res(icfr_pkg::EV_END, data_count, gap_total);
                img_open   = 1'b0;
            end
        end else begin
            if (pos <= icfr_pkg::POS_LEN_LO) len_acc = {len_acc[23:0], b};
            if (pos == icfr_pkg::POS_IDX_HI) idx_hi = b;
            if (pos == icfr_pkg::POS_CHK_HI) chunks_hi = b;
            // open a new image unless the header repeats the open one
            if (pos == icfr_pkg::POS_CHK_LO && pkt_type == icfr_pkg::KIND_HEADER) begin
                chunks_new = {chunks_hi, b};
                if (!(img_open && len_acc == img_len && chunks_new == img_chunks)) begin
                    img_len    = len_acc;
                    img_chunks = chunks_new;
                    data_count = '0;
                    want_idx   = '0;
                    gap_total  = '0;
                    img_open   = 1'b1;
                    batch[n++] = status_res(icfr_pkg::EV_BEGIN, '0, '0);
                end
            end
            // count a data packet on its index, then print its payload as hex
            if (pos == icfr_pkg::POS_IDX_LO && pkt_type == icfr_pkg::KIND_DATA && img_open) begin
                idx = {idx_hi, b};
                if (idx != want_idx) gap_total = gap_total + 16'd1;
                want_idx   = idx + 16'd1;
                data_count = data_count + 16'd1;
                hex_on     = 1'b1;
            end else if (pos >= icfr_pkg::POS_PAYLOAD && hex_on) begin
                batch[n++] = text_res(HEX_SET[b[7:4]]);
                batch[n++] = text_res(HEX_SET[b[3:0]]);
            end
        end
        if (eop) begin
            if (hex_on) begin
                batch[n++] = text_res(icfr_pkg::CHAR_CR);
                batch[n++] = text_res(icfr_pkg::CHAR_LF);
            end
            hex_on  = 1'b0;
            pkt_pos = icfr_pkg::POS_TYPE;
        end else if (pkt_pos < icfr_pkg::POS_MAX) begin
            pkt_pos = pkt_pos + 3'd1;
        end
        if (n > 0) batch[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) pending_results.push_back(batch[i]);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            o_fail_count++;
        end
    endfunction

    // Compare each result with the oldest expectation, then predict from the request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pkt_pos    <= '0;
            pkt_type   <= '0;
            len_acc    <= '0;
            chunks_hi  <= '0;
            idx_hi     <= '0;
            img_len    <= '0;
            img_chunks <= '0;
            data_count <= '0;
            want_idx   <= '0;
            gap_total  <= '0;
            img_open   <= 1'b0;
            hex_on     <= 1'b0;
            pending_results.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (pending_results.size() == 0) begin
                    $error("result with no expectation: event %0d char 0x%0h",
                           i_out.event_res, i_out.text_char);
                    o_fail_count++;
                end else begin
                    head = pending_results.pop_front();
                    check_field("event_res", head.evt, i_out.event_res);
                    check_field("text_char", head.chr, i_out.text_char);
                    check_field("image_length", head.len, i_out.image_length);
                    check_field("chunk_total", head.tot, i_out.chunk_total);
                    check_field("chunks_received", head.rcv, i_out.chunks_received);
                    check_field("gap_count", head.gaps, i_out.gap_count);
                    check_field("last", head.last, i_out.last);
                    o_checked++;
                    if (head.evt == icfr_pkg::EV_BEGIN) o_begins++;
                    if (head.evt == icfr_pkg::EV_END) o_ends++;
                end
            end
            if (i_in.valid && i_in.ready) predict_byte(i_in.rx_byte, i_in.packet_end);
        end
        o_pending = pending_results.size();
    end

endmodule

FILE: tb/tb_image_chunk_frame_receiver.sv
// Testbench top of the image chunk frame receiver: drives packet bytes and result stalls,
// gives the verdict. Depends on icfr_pkg, icfr_if, the block and icfr_frame_checker.
module tb_image_chunk_frame_receiver;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD  = 8;
    localparam int WATCHDOG_NS = 12_000_000;
    localparam int LONG_HOLD   = 200;
    localparam int PHASES      = 4;
    localparam int SEND_IDLE [PHASES] = '{0, 81, 0, 20};
    localparam int RECV_STALL [PHASES] = '{0, 0, 81, 20};

    logic i_clk = 1'b0;
    logic i_rst_n;

    icfr_in_if  byte_ch ();
    icfr_out_if res_ch ();

    int fail_count;
    int pending;
    int checked;
    int begins;
    int ends;

    int send_idle_pct;
    int recv_stall_pct;
    int hold_requests;
    int holds_done;
    int hold_left;
    int bytes_sent;

    logic [31:0] hdr_len;
    logic [15:0] hdr_chunks;
    logic [15:0] next_idx;

    image_chunk_frame_receiver dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_out   (res_ch)
    );

    icfr_frame_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (byte_ch),
        .i_out        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_begins     (begins),
        .o_ends       (ends)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Drive result ready: serve long hold-off requests, otherwise stall at random
    initial begin
        res_ch.ready = 1'b0;
        holds_done   = 0;
        hold_left    = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left == 0 && holds_done != hold_requests) begin
                holds_done++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Offer one byte after a random gap and hold it until the request is taken
    task automatic send_byte(input logic [7:0] b, input logic eop);
        while ($urandom_range(99) < send_idle_pct) begin
            byte_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        byte_ch.valid      <= 1'b1;
        byte_ch.rx_byte    <= b;
        byte_ch.packet_end <= eop;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_packet(input logic [7:0] pkt [$]);
        foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
    endtask

    task automatic send_header(input logic [31:0] len, input logic [15:0] chunks,
                               input int extra);
        logic [7:0] pkt [$];
        pkt = {icfr_pkg::KIND_HEADER, len[31:24], len[23:16], len[15:8], len[7:0],
               chunks[15:8], chunks[7:0]};
        for (int i = 0; i < extra; i++) pkt.push_back(8'($urandom_range(255)));
        send_packet(pkt);
    endtask

    task automatic send_data(input logic [15:0] idx, input int payload);
        logic [7:0] pkt [$];
        pkt = {icfr_pkg::KIND_DATA, idx[15:8], idx[7:0]};
        for (int i = 0; i < payload; i++) pkt.push_back(8'($urandom_range(255)));
        send_packet(pkt);
    endtask

    // Packet of a given type byte followed by random bytes
    task automatic send_junk(input logic [7:0] kind, input int len);
        logic [7:0] pkt [$];
        pkt = {kind};
        for (int i = 1; i < len; i++) pkt.push_back(8'($urandom_range(255)));
        send_packet(pkt);
    endtask

    // Mostly well-formed headers, data and tails with random content, some noise
    task automatic random_packets(input int target);
        int          good;
        int          sel;
        int          n;
        logic [15:0] idx;
        logic [7:0]  kind;
        good = 0;
        while (good < target) begin
            sel = $urandom_range(99);
            if (sel < 14) begin
                if ($urandom_range(2) != 0) begin
                    case ($urandom_range(5))
                        0: hdr_len = '0;
                        1: hdr_len = '1;
                        default: hdr_len = $urandom;
                    endcase
                    hdr_chunks = 16'($urandom_range(65535));
                end
                n = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
                send_header(hdr_len, hdr_chunks, n);
                good += 7 + n;
            end else if (sel < 66) begin
                idx = ($urandom_range(9) < 7) ? next_idx : 16'($urandom_range(65535));
                n = ($urandom_range(9) == 0) ? $urandom_range(7, 16) : $urandom_range(0, 4);
                send_data(idx, n);
                next_idx = idx + 16'd1;
                good += 3 + n;
            end else if (sel < 78) begin
                n = $urandom_range(1, 2);
                send_junk(icfr_pkg::KIND_TAIL, n);
                good += n;
            end else begin
                case ($urandom_range(2))
                    0: send_junk(icfr_pkg::KIND_HEADER, $urandom_range(1, 6));
                    1: send_junk(icfr_pkg::KIND_DATA, $urandom_range(1, 2));
                    default: begin
                        do kind = 8'($urandom_range(255));
                        while (kind inside {icfr_pkg::KIND_HEADER, icfr_pkg::KIND_DATA,
                                            icfr_pkg::KIND_TAIL});
                        send_junk(kind, $urandom_range(1, 5));
                    end
                endcase
            end
        end
    endtask

    // Stop a hung run
    initial begin
        #(WATCHDOG_NS);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        i_rst_n            = 1'b0;
        byte_ch.valid      = 1'b0;
        byte_ch.rx_byte    = '0;
        byte_ch.packet_end = 1'b0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        hold_requests      = 0;
        bytes_sent         = 0;
        hdr_len            = '0;
        hdr_chunks         = '0;
        next_idx           = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: ignored packets, extreme headers, index wrap, repeats, hex digits
        send_packet({icfr_pkg::KIND_TAIL});
        send_packet({icfr_pkg::KIND_DATA, 8'h00, 8'h00, 8'h55});
        send_header('1, '1, 0);
        send_packet({icfr_pkg::KIND_DATA, 8'hFF, 8'hFF, 8'h00, 8'hFF});
        send_data(16'h0000, 0);
        send_packet({icfr_pkg::KIND_DATA, 8'h05});
        send_packet({icfr_pkg::KIND_HEADER, 8'h00, 8'h00});
        send_packet({8'h7E, 8'h12});
        send_header('1, '1, 1);
        send_packet({icfr_pkg::KIND_TAIL, 8'h99});
        send_header('0, '0, 0);
        send_header(32'h1234_5678, 16'h9ABC, 0);
        send_packet({icfr_pkg::KIND_DATA});
        send_packet({icfr_pkg::KIND_DATA, 8'h00, 8'h01, 8'h01, 8'h23, 8'h45, 8'h67,
                     8'h89, 8'hAB, 8'hCD, 8'hEF});
        send_packet({icfr_pkg::KIND_TAIL});

        // Random traffic under each idling pattern; hold the receiver off once
        for (int ph = 0; ph < PHASES; ph++) begin
            send_idle_pct  = SEND_IDLE[ph];
            recv_stall_pct = RECV_STALL[ph];
            if (ph == 0) begin
                send_header(32'h0000_2000, 16'd40, 0);
                hold_requests++;
                send_data(16'h0000, 24);
                next_idx = 16'h0001;
            end
            random_packets(50);
        end

        // Close whatever image is still open
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_packet({icfr_pkg::KIND_TAIL});

        // Drain
        byte_ch.valid <= 1'b0;
        wait (pending == 0);
        repeat (8) @(posedge i_clk);
        $display("Sent %0d bytes; checked %0d results, %0d image begins, %0d image ends.",
                 bytes_sent, checked, begins, ends);
        $display("Covered idle and stall patterns, a long output hold-off, noise packets.");
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
